// File: rtl/psc_pkg.sv
package psc_pkg;

  // field widths
  localparam int COORD_W  = 32;
  localparam int NORM_W   = 18;
  localparam int OFFSET_W = 32;
  localparam int RADIUS_W = 31;
  localparam int DIST_W   = 32;
  localparam int FRAC_W   = 16;

  // datapath widths
  localparam int PROD_W  = COORD_W + NORM_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int SHIFT_W = SUM_W - FRAC_W;
  localparam int WIDE_W  = ((SHIFT_W > OFFSET_W) ? SHIFT_W : OFFSET_W) + 1;

  // 0.01 in Q16.16, rounded to nearest
  localparam logic signed [DIST_W-1:0] EPS_POS = DIST_W'(655);
  localparam logic signed [DIST_W-1:0] EPS_NEG = -EPS_POS;

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic signed [NORM_W-1:0]   NORMAL_X_RST = '0;
  localparam logic signed [NORM_W-1:0]   NORMAL_Y_RST = NORM_W'(65536);
  localparam logic signed [NORM_W-1:0]   NORMAL_Z_RST = '0;
  localparam logic signed [OFFSET_W-1:0] OFFSET_RST   = '0;

  typedef enum logic [1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_NORMAL_Z     = 2'd2,
    REG_PLANE_OFFSET = 2'd3
  } reg_e;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_SPHERE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    SIDE_BEHIND   = 2'd0,
    SIDE_FRONT    = 2'd1,
    SIDE_ON       = 2'd2,
    SIDE_STRADDLE = 2'd3
  } side_e;

  typedef struct packed {
    logic signed [NORM_W-1:0]   normal_x;
    logic signed [NORM_W-1:0]   normal_y;
    logic signed [NORM_W-1:0]   normal_z;
    logic signed [OFFSET_W-1:0] plane_offset;
  } cfg_t;

  // per-word control carried down the pipe
  typedef struct packed {
    op_e                 op;
    logic [RADIUS_W-1:0] radius;
    logic                last_vertex;
  } item_ctl_t;

endpackage

// File: rtl/psc_in_if.sv
interface psc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  op;
  logic signed [psc_pkg::COORD_W-1:0]    point_x;
  logic signed [psc_pkg::COORD_W-1:0]    point_y;
  logic signed [psc_pkg::COORD_W-1:0]    point_z;
  logic        [psc_pkg::RADIUS_W-1:0]   radius;
  logic                                  last_vertex;

  modport source (
    output valid, op, point_x, point_y, point_z, radius, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, op, point_x, point_y, point_z, radius, last_vertex,
    output ready
  );
endinterface

// File: rtl/psc_out_if.sv
interface psc_out_if;
  logic                                valid;
  logic                                ready;
  logic        [1:0]                   side;
  logic signed [psc_pkg::DIST_W-1:0]   signed_distance;

  modport source (
    output valid, side, signed_distance,
    input  ready
  );
  modport sink (
    input  valid, side, signed_distance,
    output ready
  );
endinterface

// File: rtl/psc_cfg.sv
module psc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psc_pkg::PADDR_W-1:0]   paddr,
  input  logic [psc_pkg::PDATA_W-1:0]   pwdata,
  output logic [psc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output psc_pkg::cfg_t                 cfg_o
);
  import psc_pkg::*;

  cfg_t cfg_q;
  reg_e reg_sel;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_x     <= NORMAL_X_RST;
      cfg_q.normal_y     <= NORMAL_Y_RST;
      cfg_q.normal_z     <= NORMAL_Z_RST;
      cfg_q.plane_offset <= OFFSET_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_NORMAL_X:     cfg_q.normal_x     <= pwdata[NORM_W-1:0];
        REG_NORMAL_Y:     cfg_q.normal_y     <= pwdata[NORM_W-1:0];
        REG_NORMAL_Z:     cfg_q.normal_z     <= pwdata[NORM_W-1:0];
        REG_PLANE_OFFSET: cfg_q.plane_offset <= pwdata[OFFSET_W-1:0];
      endcase
    end
  end

  // normals read back sign extended
  always_comb begin
    unique case (reg_sel)
      REG_NORMAL_X:     prdata = PDATA_W'(cfg_q.normal_x);
      REG_NORMAL_Y:     prdata = PDATA_W'(cfg_q.normal_y);
      REG_NORMAL_Z:     prdata = PDATA_W'(cfg_q.normal_z);
      REG_PLANE_OFFSET: prdata = PDATA_W'(cfg_q.plane_offset);
    endcase
  end

endmodule

// File: rtl/psc_mul.sv
module psc_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  psc_in_if.sink                              in_i,
  input  psc_pkg::cfg_t                       cfg_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output psc_pkg::item_ctl_t                  ctl_o,
  output logic signed [psc_pkg::PROD_W-1:0]   prod_x_o,
  output logic signed [psc_pkg::PROD_W-1:0]   prod_y_o,
  output logic signed [psc_pkg::PROD_W-1:0]   prod_z_o
);
  import psc_pkg::*;

  // input register
  logic                       in_v_q;
  item_ctl_t                  in_ctl_q;
  logic signed [COORD_W-1:0]  px_q, py_q, pz_q;

  // product register
  logic                       pr_v_q;
  item_ctl_t                  pr_ctl_q;
  logic signed [PROD_W-1:0]   prod_x_q, prod_y_q, prod_z_q;

  logic pr_rdy, in_rdy;
  logic signed [PROD_W-1:0]   prod_x_d, prod_y_d, prod_z_d;

  assign pr_rdy     = !pr_v_q || ready_i;
  assign in_rdy     = !in_v_q || pr_rdy;
  assign in_i.ready = in_rdy;

  assign prod_x_d = PROD_W'(px_q * cfg_i.normal_x);
  assign prod_y_d = PROD_W'(py_q * cfg_i.normal_y);
  assign prod_z_d = PROD_W'(pz_q * cfg_i.normal_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      pr_v_q <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_v_q <= in_i.valid;
      end
      if (pr_rdy) begin
        pr_v_q <= in_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_i.valid) begin
      in_ctl_q.op          <= op_e'(in_i.op);
      in_ctl_q.radius      <= in_i.radius;
      in_ctl_q.last_vertex <= in_i.last_vertex;
      px_q                 <= in_i.point_x;
      py_q                 <= in_i.point_y;
      pz_q                 <= in_i.point_z;
    end
    if (pr_rdy && in_v_q) begin
      pr_ctl_q <= in_ctl_q;
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      prod_z_q <= prod_z_d;
    end
  end

  assign valid_o  = pr_v_q;
  assign ctl_o    = pr_ctl_q;
  assign prod_x_o = prod_x_q;
  assign prod_y_o = prod_y_q;
  assign prod_z_o = prod_z_q;

endmodule

// File: rtl/psc_dist.sv
module psc_dist (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  psc_pkg::item_ctl_t                  ctl_i,
  input  logic signed [psc_pkg::PROD_W-1:0]   prod_x_i,
  input  logic signed [psc_pkg::PROD_W-1:0]   prod_y_i,
  input  logic signed [psc_pkg::PROD_W-1:0]   prod_z_i,
  input  logic signed [psc_pkg::OFFSET_W-1:0] plane_offset_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output psc_pkg::item_ctl_t                  ctl_o,
  output logic signed [psc_pkg::DIST_W-1:0]   dist_o
);
  import psc_pkg::*;

  logic                      v_q;
  item_ctl_t                 ctl_q;
  logic signed [DIST_W-1:0]  dist_q;

  logic signed [SUM_W-1:0]   sum;
  logic signed [SHIFT_W-1:0] sum_sh;
  logic signed [WIDE_W-1:0]  wide;
  logic signed [DIST_W-1:0]  dist_d;
  logic                      fits;

  assign ready_o = !v_q || ready_i;

  always_comb begin
    sum    = SUM_W'(prod_x_i) + SUM_W'(prod_y_i) + SUM_W'(prod_z_i);
    // floor division by 2^16
    sum_sh = SHIFT_W'(sum >>> FRAC_W);
    wide   = WIDE_W'(sum_sh) + WIDE_W'(plane_offset_i);
    // in range when all bits above the result sign agree
    fits   = (wide[WIDE_W-1:DIST_W-1] == '0) || (wide[WIDE_W-1:DIST_W-1] == '1);
    if (fits) begin
      dist_d = wide[DIST_W-1:0];
    end else if (wide[WIDE_W-1]) begin
      dist_d = DIST_MIN;
    end else begin
      dist_d = DIST_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctl_q  <= ctl_i;
      dist_q <= dist_d;
    end
  end

  assign valid_o = v_q;
  assign ctl_o   = ctl_q;
  assign dist_o  = dist_q;

endmodule

// File: rtl/psc_class.sv
module psc_class (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  psc_pkg::item_ctl_t                  ctl_i,
  input  logic signed [psc_pkg::DIST_W-1:0]   dist_i,
  psc_out_if.source                           out_o
);
  import psc_pkg::*;

  logic                      out_v_q;
  side_e                     side_q;
  logic signed [DIST_W-1:0]  dist_q;
  logic                      behind_q, front_q;

  logic                      fire;
  logic                      behind_now, front_now, behind_all, front_all;
  logic signed [DIST_W:0]    d_ext, abs_d, r_ext;
  logic                      has_res;
  side_e                     side_d;
  logic                      behind_d, front_d;

  assign ready_o = !out_v_q || out_o.ready;
  assign fire    = valid_i && ready_o;

  always_comb begin
    behind_now = dist_i < EPS_NEG;
    front_now  = dist_i > EPS_POS;
    behind_all = behind_q || behind_now;
    front_all  = front_q || front_now;
    d_ext      = (DIST_W+1)'(dist_i);
    abs_d      = dist_i[DIST_W-1] ? -d_ext : d_ext;
    r_ext      = (DIST_W+1)'({1'b0, ctl_i.radius});
    behind_d   = behind_q;
    front_d    = front_q;
    has_res    = 1'b1;
    side_d     = SIDE_ON;
    if (ctl_i.op == OP_SPHERE) begin
      if (abs_d < r_ext) begin
        side_d = SIDE_STRADDLE;
      end else if (d_ext >= r_ext) begin
        side_d = SIDE_FRONT;
      end else begin
        side_d = SIDE_BEHIND;
      end
    end else begin
      has_res = ctl_i.last_vertex;
      if (behind_all && front_all) begin
        side_d = SIDE_STRADDLE;
      end else if (behind_all) begin
        side_d = SIDE_BEHIND;
      end else if (front_all) begin
        side_d = SIDE_FRONT;
      end else begin
        side_d = SIDE_ON;
      end
      // polygon closes on its last vertex
      behind_d = ctl_i.last_vertex ? 1'b0 : behind_all;
      front_d  = ctl_i.last_vertex ? 1'b0 : front_all;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      behind_q <= 1'b0;
      front_q  <= 1'b0;
    end else begin
      if (ready_o) begin
        out_v_q <= fire && has_res;
      end
      if (fire) begin
        behind_q <= behind_d;
        front_q  <= front_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_res) begin
      side_q <= side_d;
      dist_q <= dist_i;
    end
  end

  assign out_o.valid           = out_v_q;
  assign out_o.side            = side_q;
  assign out_o.signed_distance = dist_q;

endmodule

// File: rtl/plane_side_classifier_top.sv
// path: an accepted input word passes the input, product, distance and result registers
// throughput: one word per cycle; the three normal multipliers work in parallel
// and every stage holds its word only while the stage after it is full
// reset: rst_ni is asynchronous, active low; it empties the pipe, clears the
// polygon flags and loads the plane normal (0, 1.0, 0) with offset 0
module plane_side_classifier_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psc_pkg::PADDR_W-1:0]   paddr,
  input  logic [psc_pkg::PDATA_W-1:0]   pwdata,
  output logic [psc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // streams
  psc_in_if.sink                        in_i,
  psc_out_if.source                     out_o
);
  import psc_pkg::*;

  cfg_t cfg;

  // multiplier stage to distance stage
  logic                       mul_valid, mul_ready;
  item_ctl_t                  mul_ctl;
  logic signed [PROD_W-1:0]   prod_x, prod_y, prod_z;

  // distance stage to classify stage
  logic                       dist_valid, dist_ready;
  item_ctl_t                  dist_ctl;
  logic signed [DIST_W-1:0]   distance;

  // plane registers; write only while the pipe is empty, which the block does not enforce
  psc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register, then the three coordinate by normal products
  psc_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg),
    .valid_o  (mul_valid),
    .ready_i  (mul_ready),
    .ctl_o    (mul_ctl),
    .prod_x_o (prod_x),
    .prod_y_o (prod_y),
    .prod_z_o (prod_z)
  );

  // exact sum, floor shift, offset add and saturation to 32 bits
  psc_dist u_dist (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (mul_valid),
    .ready_o        (mul_ready),
    .ctl_i          (mul_ctl),
    .prod_x_i       (prod_x),
    .prod_y_i       (prod_y),
    .prod_z_i       (prod_z),
    .plane_offset_i (cfg.plane_offset),
    .valid_o        (dist_valid),
    .ready_i        (dist_ready),
    .ctl_o          (dist_ctl),
    .dist_o         (distance)
  );

  // epsilon and radius compares, sticky polygon flags, result register;
  // a vertex that is not the last updates the flags and sends no word
  psc_class u_class (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dist_valid),
    .ready_o (dist_ready),
    .ctl_i   (dist_ctl),
    .dist_i  (distance),
    .out_o   (out_o)
  );

endmodule

// File: dv/tb_plane_side_classifier_top.sv
module tb_plane_side_classifier_top;
  import psc_pkg::*;

  // run limit, far above the slowest legal run of the whole stimulus
  localparam int CYCLE_LIMIT = 400000;
  // pipe holds up to four words; a few extra cycles cover a trailing vertex
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 170;
  localparam int NUM_PHASES = 12;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;
  localparam logic signed [NORM_W-1:0] NORM_MAX = {1'b0, {(NORM_W-1){1'b1}}};
  localparam logic signed [NORM_W-1:0] NORM_MIN = {1'b1, {(NORM_W-1){1'b0}}};

  // idle modes per phase: none, sender only, receiver only, both lightly
  localparam int TX_IDLE [4] = '{0, 59, 0, 12};
  localparam int RX_STALL [4] = '{0, 0, 59, 12};

  typedef struct packed {
    op_e                        op;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [COORD_W-1:0]  pz;
    logic [RADIUS_W-1:0]        radius;
    logic                       last;
  } word_t;

  typedef struct packed {
    side_e                      side;
    logic signed [DIST_W-1:0]   sdist;
  } verdict_t;

  typedef struct packed {
    word_t                      w;
    logic                       typed;
    side_e                      side;
    logic signed [DIST_W-1:0]   sdist;
  } dir_row_t;

  // directed words under the reset plane (normal along y, offset 0), where
  // the distance is simply point_y
  localparam dir_row_t DIRECTED [23] = '{
    // epsilon band edges on single-vertex polygons
    '{'{OP_VERTEX, 32'sd0, 32'sd0, 32'sd0, 31'd0, 1'b1}, 1'b1, SIDE_ON, 32'sd0},
    '{'{OP_VERTEX, 32'sd0, 32'sd655, 32'sd0, 31'd0, 1'b1}, 1'b1, SIDE_ON, 32'sd655},
    '{'{OP_VERTEX, 32'sd0, 32'sd656, 32'sd0, 31'd0, 1'b1}, 1'b1, SIDE_FRONT, 32'sd656},
    '{'{OP_VERTEX, 32'sd0, -32'sd655, 32'sd0, 31'd0, 1'b1}, 1'b1, SIDE_ON, -32'sd655},
    '{'{OP_VERTEX, 32'sd0, -32'sd656, 32'sd0, 31'd0, 1'b1}, 1'b1, SIDE_BEHIND, -32'sd656},
    // two vertices on opposite sides
    '{'{OP_VERTEX, 32'sd0, -32'sd1000, 32'sd0, 31'd0, 1'b0}, 1'b0, SIDE_ON, 32'sd0},
    '{'{OP_VERTEX, 32'sd0, 32'sd1000, 32'sd0, 31'd0, 1'b1}, 1'b1, SIDE_STRADDLE, 32'sd1000},
    // coordinate extremes
    '{'{OP_VERTEX, COORD_MIN, COORD_MAX, COORD_MAX, RADIUS_MAX, 1'b1}, 1'b1, SIDE_FRONT,
      DIST_MAX},
    '{'{OP_VERTEX, COORD_MAX, COORD_MIN, COORD_MIN, 31'd0, 1'b1}, 1'b1, SIDE_BEHIND,
      DIST_MIN},
    // sphere radius boundaries
    '{'{OP_SPHERE, 32'sd0, 32'sd100, 32'sd0, 31'd100, 1'b0}, 1'b1, SIDE_FRONT, 32'sd100},
    '{'{OP_SPHERE, 32'sd0, 32'sd99, 32'sd0, 31'd100, 1'b0}, 1'b1, SIDE_STRADDLE, 32'sd99},
    '{'{OP_SPHERE, 32'sd0, -32'sd100, 32'sd0, 31'd100, 1'b0}, 1'b1, SIDE_BEHIND, -32'sd100},
    '{'{OP_SPHERE, 32'sd0, 32'sd0, 32'sd0, 31'd0, 1'b0}, 1'b1, SIDE_FRONT, 32'sd0},
    '{'{OP_SPHERE, COORD_MAX, COORD_MIN, 32'sd0, RADIUS_MAX, 1'b1}, 1'b1, SIDE_BEHIND,
      DIST_MIN},
    '{'{OP_SPHERE, COORD_MIN, COORD_MAX, -32'sd1, RADIUS_MAX, 1'b0}, 1'b1, SIDE_FRONT,
      DIST_MAX},
    // sphere inside an open polygon leaves the flags alone
    '{'{OP_VERTEX, 32'sd0, -32'sd5000, 32'sd0, 31'd0, 1'b0}, 1'b0, SIDE_ON, 32'sd0},
    '{'{OP_SPHERE, 32'sd0, -32'sd3, 32'sd0, 31'd1, 1'b1}, 1'b1, SIDE_BEHIND, -32'sd3},
    '{'{OP_VERTEX, 32'sd0, 32'sd2, 32'sd0, 31'd0, 1'b1}, 1'b1, SIDE_BEHIND, 32'sd2},
    '{'{OP_SPHERE, -32'sd1, 32'sd0, -32'sd1, RADIUS_MAX, 1'b0}, 1'b1, SIDE_STRADDLE,
      32'sd0},
    // flags cleared after a result
    '{'{OP_VERTEX, -32'sd1, -32'sd1, -32'sd1, RADIUS_MAX, 1'b0}, 1'b0, SIDE_ON, 32'sd0},
    '{'{OP_VERTEX, 32'sd0, 32'sd0, 32'sd0, 31'd0, 1'b1}, 1'b1, SIDE_ON, 32'sd0},
    '{'{OP_VERTEX, 32'sd0, 32'sd700, 32'sd0, 31'd0, 1'b0}, 1'b0, SIDE_ON, 32'sd0},
    '{'{OP_VERTEX, 32'sd0, 32'sd0, 32'sd0, 31'd0, 1'b1}, 1'b1, SIDE_FRONT, 32'sd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  psc_in_if  in_if ();
  psc_out_if out_if ();

  plane_side_classifier_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  // predictor state: plane as the block should hold it, plus polygon flags
  cfg_t     plane_cfg;
  bit       behind_seen;
  bit       front_seen;
  verdict_t verdict_q [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  bit  hold_req = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // exact dot product, floor shift by the fraction, offset, saturate
  function automatic logic signed [DIST_W-1:0] dist_to_plane(input word_t w);
    logic signed [63:0] cx, cy, cz, nx, ny, nz, off, acc;
    cx = w.px;
    cy = w.py;
    cz = w.pz;
    nx = plane_cfg.normal_x;
    ny = plane_cfg.normal_y;
    nz = plane_cfg.normal_z;
    off = plane_cfg.plane_offset;
    acc = cx * nx + cy * ny + cz * nz;
    acc = (acc >>> FRAC_W) + off;
    if (acc > DIST_MAX) return DIST_MAX;
    if (acc < DIST_MIN) return DIST_MIN;
    return acc[DIST_W-1:0];
  endfunction

  // returns 1 when the word produces a result, updating the polygon flags
  function automatic bit classify_word(input word_t w, output verdict_t v);
    logic signed [DIST_W-1:0] d;
    logic signed [63:0] dd, ad, rr;
    d = dist_to_plane(w);
    v.sdist = d;
    v.side = SIDE_ON;
    if (w.op == OP_SPHERE) begin
      dd = d;
      ad = (dd < 0) ? -dd : dd;
      rr = w.radius;
      if (ad < rr) v.side = SIDE_STRADDLE;
      else if (dd >= rr) v.side = SIDE_FRONT;
      else v.side = SIDE_BEHIND;
      return 1'b1;
    end
    if (d < EPS_NEG) behind_seen = 1'b1;
    if (d > EPS_POS) front_seen = 1'b1;
    if (!w.last) return 1'b0;
    if (behind_seen && front_seen) v.side = SIDE_STRADDLE;
    else if (behind_seen) v.side = SIDE_BEHIND;
    else if (front_seen) v.side = SIDE_FRONT;
    behind_seen = 1'b0;
    front_seen = 1'b0;
    return 1'b1;
  endfunction

  // offer one word, with random gaps ahead of it; predict once it is taken
  task automatic push_word(input word_t w, input bit typed = 1'b0,
                           input verdict_t typed_v = '0);
    verdict_t v;
    bit       has;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= w.op;
    in_if.point_x     <= w.px;
    in_if.point_y     <= w.py;
    in_if.point_z     <= w.pz;
    in_if.radius      <= w.radius;
    in_if.last_vertex <= w.last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    has = classify_word(w, v);
    if (typed) verdict_q.push_back(typed_v);
    else if (has) verdict_q.push_back(v);
  endtask

  // drop valid, wait for every awaited result, then let the pipe drain
  task automatic settle();
    in_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // setup then access; psel stays up across back-to-back writes
  task automatic apb_write(input reg_e r, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  // upper bits of the normal writes carry junk that the block must drop
  task automatic write_plane(input cfg_t c);
    apb_write(REG_NORMAL_X, {(PDATA_W-NORM_W)'($urandom), c.normal_x});
    apb_write(REG_NORMAL_Y, {(PDATA_W-NORM_W)'($urandom), c.normal_y});
    apb_write(REG_NORMAL_Z, {(PDATA_W-NORM_W)'($urandom), c.normal_z});
    apb_write(REG_PLANE_OFFSET, c.plane_offset);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    plane_cfg = c;
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0, 1:       return $urandom;
      2, 3, 4, 5: return $urandom_range(524288) - 262144;
      6, 7:       return $urandom_range(4000) - 2000;
      8: begin
        case ($urandom_range(3))
          0:       return COORD_MAX;
          1:       return COORD_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default:    return $urandom_range(1400) - 700;
    endcase
  endfunction

  function automatic logic signed [NORM_W-1:0] rand_normal();
    case ($urandom_range(3))
      0: return NORM_W'($urandom);
      1: begin
        case ($urandom_range(2))
          0:       return 18'sd65536;
          1:       return -18'sd65536;
          default: return '0;
        endcase
      end
      2: return NORM_W'($urandom_range(32768) - 16384);
      default: return $urandom_range(1) ? NORM_MAX : NORM_MIN;
    endcase
  endfunction

  function automatic cfg_t rand_plane();
    cfg_t c;
    c.normal_x = rand_normal();
    c.normal_y = rand_normal();
    c.normal_z = rand_normal();
    case ($urandom_range(2))
      0:       c.plane_offset = $urandom;
      1:       c.plane_offset = $urandom_range(8192) - 4096;
      default: c.plane_offset = $urandom_range(1) ? DIST_MAX : DIST_MIN;
    endcase
    return c;
  endfunction

  // radius near |d| hits the strict and non-strict compares
  task automatic send_sphere();
    word_t w;
    logic signed [63:0] ad;
    w.op = OP_SPHERE;
    w.px = rand_coord();
    w.py = rand_coord();
    w.pz = rand_coord();
    w.last = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: w.radius = RADIUS_W'($urandom);
      1: w.radius = RADIUS_W'($urandom_range(5000));
      default: begin
        ad = dist_to_plane(w);
        if (ad < 0) ad = -ad;
        ad = ad + $urandom_range(2) - 1;
        if (ad < 0) ad = 0;
        if (ad > 64'(RADIUS_MAX)) ad = 64'(RADIUS_MAX);
        w.radius = ad[RADIUS_W-1:0];
      end
    endcase
    push_word(w);
  endtask

  task automatic send_polygon(output int n);
    word_t w;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if (i != 0 && $urandom_range(7) == 0) send_sphere();
      w.op = OP_VERTEX;
      w.px = rand_coord();
      w.py = rand_coord();
      w.pz = rand_coord();
      w.radius = RADIUS_W'($urandom);
      w.last = (i == n - 1);
      push_word(w);
    end
  endtask

  task automatic send_random(input int count);
    int sent;
    int n;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(3) == 0) begin
        send_sphere();
        sent++;
      end else begin
        send_polygon(n);
        sent += n;
      end
    end
  endtask

  // receiver: random stalls, or a long hold when asked for one
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // compare each taken result against the oldest prediction
  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result word: side %0d, signed_distance %0d",
               out_if.side, out_if.signed_distance);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (out_if.side !== want.side) begin
          $error("side: expected %0d, actual %0d", want.side, out_if.side);
          mismatches++;
        end
        if (out_if.signed_distance !== want.sdist) begin
          $error("signed_distance: expected %0d, actual %0d",
                 want.sdist, out_if.signed_distance);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    verdict_t v;
    cfg_t     c;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.op = OP_VERTEX;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.point_z = '0;
    in_if.radius = '0;
    in_if.last_vertex = 1'b0;
    plane_cfg = '{NORMAL_X_RST, NORMAL_Y_RST, NORMAL_Z_RST, OFFSET_RST};
    behind_seen = 1'b0;
    front_seen = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words on the reset plane, no idling
    foreach (DIRECTED[i]) begin
      v.side = DIRECTED[i].side;
      v.sdist = DIRECTED[i].sdist;
      push_word(DIRECTED[i].w, DIRECTED[i].typed, v);
    end
    send_random(RANDOM_PER_PHASE);

    for (int p = 1; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        1: c = '{NORM_MAX, NORM_MAX, NORM_MAX, DIST_MAX};
        2: c = '{NORM_MIN, NORM_MIN, NORM_MIN, DIST_MIN};
        3: c = '{'0, '0, '0, 32'($urandom)};
        // unit normal along y with a small offset keeps points near the band
        4: c = '{'0, 18'sd65536, '0, 32'($urandom_range(2000) - 1000)};
        default: c = rand_plane();
      endcase
      write_plane(c);
      tx_idle_pct = TX_IDLE[p % 4];
      rx_stall_pct = RX_STALL[p % 4];
      // long receiver hold while the sender keeps offering words
      if (p == 4) hold_req = 1'b1;
      send_random(RANDOM_PER_PHASE);
    end

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
